### hdl/sedd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smooth-extrema DMP detector package
// Shared constants, payload types and register indexes.
// ----------------------------------------------------------------------------
package sedd_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int TOL_BITS       = 16;
   localparam int WIN            = 7;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 31;
   localparam int ALPHA_BITS     = FRAC_BITS_DEF + 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_REL_TOL      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ABS_TOL      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ROUNDOFF_TOL = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_GLOBAL_SCALE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOL_MODE     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SMOOTH_EXEMPT = 3'd5;

   typedef struct packed {
      logic signed [VALUE_BITS_DEF-1:0] ref_value;
      logic signed [VALUE_BITS_DEF-1:0] cand_value;
      logic                             line_start;
   } req_type;

   typedef struct packed {
      logic                  trouble;
      logic                  dmp_violation;
      logic [ALPHA_BITS-1:0] smooth_alpha;
   } rsp_type;

   // Settings for the tolerance checks and the smooth-extrema exemption.
   typedef struct packed {
      logic [15:0] rel_tol;
      logic [30:0] abs_tol;
      logic [15:0] roundoff_tol;
      logic [30:0] global_scale;
      logic        tol_mode;
      logic        use_smooth_exempt;
   } csr_type;

   // Register values after reset: smooth extrema are exempt, all else is zero.
   localparam csr_type CSR_RESET = '{
      rel_tol:           16'd0,
      abs_tol:           31'd0,
      roundoff_tol:      16'd0,
      global_scale:      31'd0,
      tol_mode:          1'b0,
      use_smooth_exempt: 1'b1
   };

endpackage

### hdl/sedd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// One stage of the sliding window: holds one value and its line-fill flag
// and hands them to the next cell whenever the window shifts.
// ----------------------------------------------------------------------------
module sedd_cell #(
   parameter int VALUE_BITS = sedd_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic                         clear_fill,
   input  logic signed [VALUE_BITS-1:0] value_in,
   input  logic                         fill_in,
   output logic signed [VALUE_BITS-1:0] value_out,
   output logic                         fill_out
);
   import sedd_pkg::*;

   logic signed [VALUE_BITS-1:0] value_ff;
   logic                         fill_ff;
   logic                         fill_in_w;

   // A new line invalidates every older cell.
   assign fill_in_w = fill_in & ~clear_fill;

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 1'b0;
      end else if (shift) begin
         fill_ff <= fill_in_w;
      end
   end

   assign value_out = value_ff;
   assign fill_out  = fill_ff;
endmodule

### hdl/sedd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha ratio divider
// Restoring divider, one quotient bit per cycle, returning
// floor(num * 2^FRAC_BITS / den) clipped to one.
// ----------------------------------------------------------------------------
module sedd_divider #(
   parameter int NUM_BITS  = 36,
   parameter int FRAC_BITS = sedd_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_BITS-1:0]  num,
   input  logic [NUM_BITS-1:0]  den,
   output logic                 done,
   output logic [FRAC_BITS:0]   quot
);
   import sedd_pkg::*;

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

   logic [NUM_BITS:0]   rem_ff, rem_in, rem_sh;
   logic [NUM_BITS-1:0] den_ff;
   logic [FRAC_BITS:0]  quot_ff, quot_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   // One quotient bit per step.
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[NUM_BITS-1:0], 1'b0};
      if (start) begin
         if (num >= den) begin
            quot_in = {1'b1, {FRAC_BITS{1'b0}}};
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {1'b0, num};
            quot_in = '0;
            cnt_in  = CNT_BITS'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in  = rem_sh - {1'b0, den_ff};
            quot_in = {quot_ff[FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[FRAC_BITS-1:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (start) begin
         den_ff <= den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

### hdl/smooth_extrema_dmp_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smooth-extrema DMP detector
// Relaxed discrete-maximum-principle check with smooth-extrema exemption
// over a seven-cell window streaming along a 1D line.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  req     | in        | req_valid/stall  | sedd_pkg::req_type
//  rsp     | out       | rsp_valid/stall  | sedd_pkg::rsp_type
//  csr     | in        | csr_write        | csr_index, csr_data
//
// A transaction that gives no result (partial window) leaves the input free.
// One that gives a result holds off new transactions while the six
// alpha ratios run one after another through a single bit-serial divider, and
// a ratio that clips to one at once skips the bit-serial steps.
// The result waits in an output register; a new transaction is taken as soon
// as the previous result is registered, even while it is stalled.
// Reset is synchronous: it clears window fill and handshake state, resets CSRs.
// ----------------------------------------------------------------------------
module smooth_extrema_dmp_detector #(
   parameter int VALUE_BITS = sedd_pkg::VALUE_BITS_DEF,
   parameter int FRAC_BITS  = sedd_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sedd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sedd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [sedd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sedd_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import sedd_pkg::*;

   localparam int DB  = VALUE_BITS + 2;   // width of second differences
   localparam int NB  = DB + 2;           // 4 * |clip| fits here
   localparam int WB  = VALUE_BITS + 2;   // bound compare width
   localparam int MB  = VALUE_BITS + 1;   // magnitude width
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TOL  = 5'b00010,
      ST_DIFF = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   csr_type csr_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_REL_TOL:       csr_ff.rel_tol <= csr_data[15:0];
            REG_ABS_TOL:       csr_ff.abs_tol <= csr_data[30:0];
            REG_ROUNDOFF_TOL:  csr_ff.roundoff_tol <= csr_data[15:0];
            REG_GLOBAL_SCALE:  csr_ff.global_scale <= csr_data[30:0];
            REG_TOL_MODE:      csr_ff.tol_mode <= csr_data[0];
            REG_SMOOTH_EXEMPT: csr_ff.use_smooth_exempt <= csr_data[0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // Chain of window cells for stage-input values; fill flags travel along.
   logic signed [VALUE_BITS-1:0] ref_q  [WIN];
   logic                         fill_q [WIN];
   logic signed [VALUE_BITS-1:0] cand_q [4];
   logic                         fill_d [4];

   // The newest cell always belongs to the current line, so a line start
   // clears only the older cells.
   for (genvar g = 0; g < WIN; g++) begin : g_ref
      sedd_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
         .clock(clock), .reset(reset), .shift(accept),
         .clear_fill((g == WIN - 1) ? 1'b0 : req_data.line_start),
         .value_in((g == WIN - 1) ? VALUE_BITS'(req_data.ref_value) : ref_q[g + 1]),
         .fill_in((g == WIN - 1) ? 1'b1 : fill_q[g + 1]),
         .value_out(ref_q[g]), .fill_out(fill_q[g])
      );
   end
   for (genvar g = 0; g < 4; g++) begin : g_cand
      sedd_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
         .clock(clock), .reset(reset), .shift(accept), .clear_fill(1'b0),
         .value_in((g == 3) ? VALUE_BITS'(req_data.cand_value) : cand_q[g + 1]),
         .fill_in(1'b0),
         .value_out(cand_q[g]), .fill_out(fill_d[g])
      );
   end

   // Window is full when its oldest cell still belongs to this line.
   logic window_full;
   assign window_full = fill_q[0];

   // Bounds over the centre and its neighbours.
   logic signed [VALUE_BITS-1:0] qmn, qmx;
   always_comb begin
      qmn = ref_q[3];
      qmx = ref_q[3];
      if (ref_q[2] < qmn) qmn = ref_q[2];
      if (ref_q[4] < qmn) qmn = ref_q[4];
      if (ref_q[2] > qmx) qmx = ref_q[2];
      if (ref_q[4] > qmx) qmx = ref_q[4];
   end

   function automatic logic [MB-1:0] mag_f(input logic signed [VALUE_BITS-1:0] x);
      logic signed [MB-1:0] xe;
      xe = MB'(x);
      return (xe < 0) ? MB'(-xe) : MB'(xe);
   endfunction

   // Tolerance products, registered after the multiply.
   logic [MB-1:0] prod_mn_ff, prod_mx_ff, prod_gs_ff, prod_rmn_ff, prod_rmx_ff;
   logic [MB+TOL_BITS-1:0] p_mn, p_mx, p_gs, p_rmn, p_rmx;
   assign p_mn  = (MB+TOL_BITS)'(csr_ff.rel_tol) * (MB+TOL_BITS)'(mag_f(qmn));
   assign p_mx  = (MB+TOL_BITS)'(csr_ff.rel_tol) * (MB+TOL_BITS)'(mag_f(qmx));
   assign p_gs  = (MB+TOL_BITS)'(csr_ff.rel_tol) * (MB+TOL_BITS)'(csr_ff.global_scale);
   assign p_rmn = (MB+TOL_BITS)'(csr_ff.roundoff_tol) * (MB+TOL_BITS)'(mag_f(qmn));
   assign p_rmx = (MB+TOL_BITS)'(csr_ff.roundoff_tol) * (MB+TOL_BITS)'(mag_f(qmx));

   // Second differences per detector, computed in the tolerance step.
   logic signed [DB-1:0] e_ff [3], l_ff [3], r_ff [3];

   // Divider sequencing over six ratios.
   logic [2:0]           job_ff, job_in;
   logic                 div_start;
   logic                 div_done;
   logic [FRAC_BITS:0]   div_quot;
   logic [NB-1:0]        div_num, div_den;
   logic [FRAC_BITS:0]   alpha_ff, alpha_in;
   logic                 nad_ff;

   function automatic logic [NB-1:0] amag_f(input logic signed [DB-1:0] x);
      logic signed [NB-1:0] xe;
      xe = NB'(x);
      return (xe < 0) ? NB'(-xe) : NB'(xe);
   endfunction

   always_comb begin
      logic signed [DB-1:0] sel;
      if (job_ff[0]) sel = r_ff[job_ff[2:1]];
      else           sel = l_ff[job_ff[2:1]];
      div_num = amag_f(sel) << 2;
      div_den = amag_f(e_ff[job_ff[2:1]]);
   end

   sedd_divider #(.NUM_BITS(NB), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_quot)
   );

   logic start_ff;
   assign div_start = start_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      alpha_in = alpha_ff;
      case (state_ff)
         ST_IDLE: if (accept && (fill_q[1] || (WIN == 1))
                              && !req_data.line_start) state_in = ST_TOL;
         ST_TOL:  state_in = ST_DIFF;
         ST_DIFF: begin
            state_in = ST_DIV;
            job_in   = '0;
            alpha_in = ONE;
         end
         ST_DIV: begin
            if (div_done) begin
               if (e_ff[job_ff[2:1]] != 0 && div_quot < alpha_in) alpha_in = div_quot;
               if (job_ff == 3'd5) state_in = ST_OUT;
               else job_in = job_ff + 3'd1;
            end
         end
         ST_OUT: if (!rsp_valid || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == ST_DIFF) ||
                     (state_ff == ST_DIV && div_done && job_ff != 3'd5);
      end
      job_ff   <= job_in;
      alpha_ff <= alpha_in;
   end

   // Registered products and difference terms.
   always_ff @(posedge clock) begin
      if (state_ff == ST_TOL) begin
         prod_mn_ff  <= MB'(p_mn  >> TOL_BITS);
         prod_mx_ff  <= MB'(p_mx  >> TOL_BITS);
         prod_gs_ff  <= MB'(p_gs  >> TOL_BITS);
         prod_rmn_ff <= MB'(p_rmn >> TOL_BITS);
         prod_rmx_ff <= MB'(p_rmx >> TOL_BITS);
         for (int k = 0; k < 3; k++) begin
            logic signed [DB-1:0] dm, dc, dp, e, l, r;
            dm = DB'(ref_q[k + 2]) - DB'(ref_q[k]);
            dc = DB'(ref_q[k + 3]) - DB'(ref_q[k + 1]);
            dp = DB'(ref_q[k + 4]) - DB'(ref_q[k + 2]);
            e  = dp - dm;
            l  = dm - dc;
            r  = dp - dc;
            if (e > 0) begin
               l = (l < 0) ? l : '0;
               r = (r > 0) ? r : '0;
            end else begin
               l = (l > 0) ? l : '0;
               r = (r < 0) ? r : '0;
            end
            e_ff[k] <= e;
            l_ff[k] <= l;
            r_ff[k] <= r;
         end
      end
   end

   // Violation check on registered tolerances, compared as signed values.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) begin
         logic [MB-1:0] em, ep, abs_e;
         abs_e = MB'(csr_ff.abs_tol);
         if (csr_ff.tol_mode) begin
            em = (prod_gs_ff > abs_e) ? prod_gs_ff : abs_e;
            ep = em;
         end else begin
            em = (prod_mn_ff > abs_e) ? prod_mn_ff : abs_e;
            ep = (prod_mx_ff > abs_e) ? prod_mx_ff : abs_e;
         end
         if (prod_rmn_ff > em) em = prod_rmn_ff;
         if (prod_rmx_ff > ep) ep = prod_rmx_ff;
         nad_ff <= (WB'(cand_q[0]) < WB'(qmn) - $signed(WB'(em))) ||
                   (WB'(cand_q[0]) > WB'(qmx) + $signed(WB'(ep)));
      end
   end

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.dmp_violation <= nad_ff;
         rsp_ff.trouble       <= nad_ff && (!csr_ff.use_smooth_exempt || alpha_ff < ONE);
         rsp_ff.smooth_alpha  <= ALPHA_BITS'(alpha_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic unused_w;
   assign unused_w = window_full ^ fill_d[0] ^ fill_d[1] ^ fill_d[2] ^ fill_d[3];
endmodule

### hdl/sedd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smooth-extrema DMP detector checker
// Port-level properties of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module sedd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sedd_pkg::rsp_type rsp_data
);
   import sedd_pkg::*;

   // A stalled result stays.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // Alpha never exceeds one.
   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.smooth_alpha <= 17'h10000)
      else $error("alpha above one");

   // Trouble implies a violation.
   a_trouble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trouble |-> rsp_data.dmp_violation)
      else $error("trouble without violation");

   // Out of reset the block takes transactions.
   a_ready: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("stall right after reset");
endmodule

bind smooth_extrema_dmp_detector sedd_checker u_sedd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
